>>> sv/tbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_pkg
// widths, constants and the divider work item shared by the weights unit
// ----------------------------------------------------------------------------
package tbw_pkg;

  // coordinate and config port widths
  localparam int COORD_W   = 12;
  localparam int CFG_IDX_W = 3;

  // config register indexes; the last two slots are not mapped
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X     = CFG_IDX_W'(0),
    REG_A_Y     = CFG_IDX_W'(1),
    REG_B_X     = CFG_IDX_W'(2),
    REG_B_Y     = CFG_IDX_W'(3),
    REG_C_X     = CFG_IDX_W'(4),
    REG_C_Y     = CFG_IDX_W'(5),
    REG_SPARE_6 = CFG_IDX_W'(6),
    REG_SPARE_7 = CFG_IDX_W'(7)
  } cfg_reg_t;

  // datapath widths
  localparam int EDGE_W     = COORD_W + 1;        // signed coordinate difference
  localparam int PROD_W     = 2 * EDGE_W;         // edge product
  localparam int CROSS_W    = PROD_W + 1;         // cross product term
  localparam int NUMER_W    = CROSS_W + 2;        // 1 - (u0+u1)/u2 numerator
  localparam int MAG_W      = NUMER_W - 1;        // numerator magnitude
  localparam int DEN_W      = CROSS_W - 1;        // divisor magnitude
  localparam int FRAC_W     = 16;
  localparam int WEIGHT_W   = 32;
  localparam int QUO_W      = WEIGHT_W + 1;       // quotient bits kept by the divider
  localparam int DIVIDEND_W = MAG_W + FRAC_W;
  localparam int HEAD_W     = DIVIDEND_W - QUO_W; // dividend bits above the quotient

  // lanes of the divider, one per weight
  localparam int LANES  = 3;
  localparam int LANE_A = 0;
  localparam int LANE_B = 1;
  localparam int LANE_C = 2;

  // fixed point constants
  localparam logic [WEIGHT_W-1:0] W_POS_ONE = WEIGHT_W'(1) << FRAC_W;
  localparam logic [WEIGHT_W-1:0] W_NEG_ONE = ~W_POS_ONE + WEIGHT_W'(1);
  localparam logic [WEIGHT_W-1:0] W_MAX     = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] W_MIN     = {1'b1, {(WEIGHT_W-1){1'b0}}};
  localparam logic [QUO_W-1:0]    Q_NEG_LIM = QUO_W'(1) << (WEIGHT_W - 1);

  // one item in flight through the divider
  typedef struct packed {
    logic [DEN_W-1:0]                den;
    logic                            degen;
    logic [LANES-1:0]                neg;
    logic [LANES-1:0]                ovf;
    logic [LANES-1:0][DEN_W-1:0]     rem;
    logic [LANES-1:0][QUO_W-1:0]     sh;   // dividend bits out, quotient bits in
  } div_work_t;

endpackage

>>> sv/tbw_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_pixel_if
// pixel channel: valid/ready with the pixel coordinates
// ----------------------------------------------------------------------------
interface tbw_pixel_if import tbw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> sv/tbw_weight_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_weight_if
// result channel: valid/ready with three q15.16 weights and the degenerate flag
// ----------------------------------------------------------------------------
interface tbw_weight_if import tbw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight_a;
  logic signed [WEIGHT_W-1:0] weight_b;
  logic signed [WEIGHT_W-1:0] weight_c;
  logic                       degenerate;

  modport source (output valid, output weight_a, output weight_b, output weight_c,
                  output degenerate, input ready);
  modport sink   (input valid, input weight_a, input weight_b, input weight_c,
                  input degenerate, output ready);
endinterface

>>> sv/tbw_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_div_pipe
// pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor
// ----------------------------------------------------------------------------
module tbw_div_pipe import tbw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output div_work_t out_work
);

  localparam int STEPS = QUO_W;

  logic      vld_r    [STEPS];
  logic      vld_in   [STEPS];
  logic      adv      [STEPS];
  div_work_t work_r   [STEPS];
  div_work_t stage_in [STEPS];
  div_work_t work_nxt [STEPS];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      logic [LANES-1:0][DEN_W:0] trial;
      logic [LANES-1:0][DEN_W:0] diff;

      if (k == 0) begin : g_first
        assign stage_in[k] = in_work;
        assign vld_in[k]   = in_valid;
      end else begin : g_next
        assign stage_in[k] = work_r[k-1];
        assign vld_in[k]   = vld_r[k-1];
      end

      // stage moves when empty or when the next one takes its transaction
      if (k == STEPS - 1) begin : g_last
        assign adv[k] = !vld_r[k] || out_ready;
      end else begin : g_mid
        assign adv[k] = !vld_r[k] || adv[k+1];
      end

      always_comb begin
        work_nxt[k] = stage_in[k];
        for (int l = 0; l < LANES; l++) begin
          trial[l] = {stage_in[k].rem[l], stage_in[k].sh[l][QUO_W-1]};
          diff[l]  = trial[l] - {1'b0, stage_in[k].den};
          if (trial[l] >= {1'b0, stage_in[k].den}) begin
            work_nxt[k].rem[l] = diff[l][DEN_W-1:0];
            work_nxt[k].sh[l]  = {stage_in[k].sh[l][QUO_W-2:0], 1'b1};
          end else begin
            work_nxt[k].rem[l] = trial[l][DEN_W-1:0];
            work_nxt[k].sh[l]  = {stage_in[k].sh[l][QUO_W-2:0], 1'b0};
          end
          // head already at or above divisor: quotient needs more than QUO_W bits
          if (k == 0) begin
            work_nxt[k].ovf[l] = stage_in[k].ovf[l] |
                                 ({1'b0, stage_in[k].rem[l]} >= {1'b0, stage_in[k].den});
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (adv[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k]) begin
          work_r[k] <= work_nxt[k];
        end
      end
    end
  endgenerate

  assign in_ready  = adv[0];
  assign out_valid = vld_r[STEPS-1];
  assign out_work  = work_r[STEPS-1];

`ifndef SYNTHESIS
  // restoring invariant: remainder stays below divisor unless the head overflowed
  a_rem_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_work.degen && !out_work.ovf[LANE_A]
      |-> out_work.rem[LANE_A] < out_work.den)
    else $error("lane a remainder not below divisor");

  a_rem_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_work.degen && !out_work.ovf[LANE_B]
      |-> out_work.rem[LANE_B] < out_work.den)
    else $error("lane b remainder not below divisor");

  a_rem_c: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_work.degen && !out_work.ovf[LANE_C]
      |-> out_work.rem[LANE_C] < out_work.den)
    else $error("lane c remainder not below divisor");
`endif

endmodule

>>> sv/triangle_barycentric_weights_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_weights_unit
// barycentric weights of a pixel against a configured 2d triangle, q15.16
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  in_pix    in   valid/ready          pixel_x, pixel_y (12 bit unsigned)
//  out_wgt   out  valid/ready          weight_a/b/c (32 bit signed q15.16),
//                                      degenerate
//  cfg_*     in   cfg_we, no wait      cfg_index (0..5 mapped), cfg_data (12 bit)
//
//  one transaction per cycle sustained while out_wgt is ready; in_pix reaches
//  out_wgt through 6 front stages, 33 divider stages and 1 output stage;
//  the 33-stage divider, one quotient bit per stage, sets the depth
//  every stage holds its transaction when the next one is full and stalled;
//  bubbles collapse, so in_pix stays ready while empty stages remain
//  rst_n (synchronous, active low) clears all valid bits and the vertex
//  registers; config must be written only while no transaction is in flight;
//  the block itself does not enforce this
module triangle_barycentric_weights_unit import tbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  tbw_pixel_if.sink            in_pix,
  tbw_weight_if.source         out_wgt
);

  localparam int NPROD = 6;

  // vertex registers
  logic [COORD_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;

  // front pipeline valid bits and advance chain
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv_out;

  // stage 1: edge vectors
  logic signed [EDGE_W-1:0]  ex_r   [LANES];
  logic signed [EDGE_W-1:0]  ey_r   [LANES];
  logic signed [EDGE_W-1:0]  ex_nxt [LANES];
  logic signed [EDGE_W-1:0]  ey_nxt [LANES];
  // stage 2: products
  logic signed [PROD_W-1:0]  prod_r   [NPROD];
  logic signed [PROD_W-1:0]  prod_nxt [NPROD];
  // stage 3: cross product u0, u1, u2
  logic signed [CROSS_W-1:0] u_r   [LANES];
  logic signed [CROSS_W-1:0] u_nxt [LANES];
  // stage 4: signed numerators and divisor
  logic signed [NUMER_W-1:0] numer_r   [LANES];
  logic signed [NUMER_W-1:0] numer_nxt [LANES];
  logic signed [CROSS_W-1:0] den_s_r;
  // stage 5: magnitudes and signs
  logic [MAG_W-1:0]          mag_r   [LANES];
  logic [MAG_W-1:0]          mag_nxt [LANES];
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic [LANES-1:0]          neg_r, neg_nxt;
  logic                      degen_r, degen_nxt;
  // stage 6: rounded dividend split for the divider
  logic [LANES-1:0][DIVIDEND_W-1:0] dividend;
  div_work_t                 s6_work_r, s6_work_nxt;

  // divider and output
  logic                      div_in_ready;
  logic                      div_out_valid;
  div_work_t                 div_out_work;
  logic [WEIGHT_W-1:0]       weight_r   [LANES];
  logic [WEIGHT_W-1:0]       weight_nxt [LANES];
  logic                      out_degen_r;
  logic                      out_vld_r;

  // --------------------------------------------------------------------------
  // configuration writes; indexes past the last register are dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_A_X: ax_r <= cfg_data;
        REG_A_Y: ay_r <= cfg_data;
        REG_B_X: bx_r <= cfg_data;
        REG_B_Y: by_r <= cfg_data;
        REG_C_X: cx_r <= cfg_data;
        REG_C_Y: cy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // advance chain: a stage loads when empty or when its successor moves
  // --------------------------------------------------------------------------
  assign adv_out = !out_vld_r || out_wgt.ready;
  assign adv6    = !s6_vld_r  || div_in_ready;
  assign adv5    = !s5_vld_r  || adv6;
  assign adv4    = !s4_vld_r  || adv5;
  assign adv3    = !s3_vld_r  || adv4;
  assign adv2    = !s2_vld_r  || adv3;
  assign adv1    = !s1_vld_r  || adv2;

  assign in_pix.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv1)    s1_vld_r  <= in_pix.valid;
      if (adv2)    s2_vld_r  <= s1_vld_r;
      if (adv3)    s3_vld_r  <= s2_vld_r;
      if (adv4)    s4_vld_r  <= s3_vld_r;
      if (adv5)    s5_vld_r  <= s4_vld_r;
      if (adv6)    s6_vld_r  <= s5_vld_r;
      if (adv_out) out_vld_r <= div_out_valid;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: ex = (C-A, B-A, A-P) and ey likewise
  // --------------------------------------------------------------------------
  always_comb begin
    ex_nxt[0] = $signed({1'b0, cx_r}) - $signed({1'b0, ax_r});
    ex_nxt[1] = $signed({1'b0, bx_r}) - $signed({1'b0, ax_r});
    ex_nxt[2] = $signed({1'b0, ax_r}) - $signed({1'b0, in_pix.pixel_x});
    ey_nxt[0] = $signed({1'b0, cy_r}) - $signed({1'b0, ay_r});
    ey_nxt[1] = $signed({1'b0, by_r}) - $signed({1'b0, ay_r});
    ey_nxt[2] = $signed({1'b0, ay_r}) - $signed({1'b0, in_pix.pixel_y});
  end

  // --------------------------------------------------------------------------
  // stage 2: the six 13x13 products of the cross product
  // --------------------------------------------------------------------------
  always_comb begin
    prod_nxt[0] = ex_r[1] * ey_r[2];
    prod_nxt[1] = ex_r[2] * ey_r[1];
    prod_nxt[2] = ex_r[2] * ey_r[0];
    prod_nxt[3] = ex_r[0] * ey_r[2];
    prod_nxt[4] = ex_r[0] * ey_r[1];
    prod_nxt[5] = ex_r[1] * ey_r[0];
  end

  // --------------------------------------------------------------------------
  // stage 3: u0, u1, u2
  // --------------------------------------------------------------------------
  always_comb begin
    u_nxt[0] = CROSS_W'(prod_r[0]) - CROSS_W'(prod_r[1]);
    u_nxt[1] = CROSS_W'(prod_r[2]) - CROSS_W'(prod_r[3]);
    u_nxt[2] = CROSS_W'(prod_r[4]) - CROSS_W'(prod_r[5]);
  end

  // --------------------------------------------------------------------------
  // stage 4: numerators u2-u0-u1, u1, u0 over divisor u2
  // --------------------------------------------------------------------------
  always_comb begin
    numer_nxt[LANE_A] = NUMER_W'(u_r[2]) - NUMER_W'(u_r[0]) - NUMER_W'(u_r[1]);
    numer_nxt[LANE_B] = NUMER_W'(u_r[1]);
    numer_nxt[LANE_C] = NUMER_W'(u_r[0]);
  end

  // --------------------------------------------------------------------------
  // stage 5: sign-magnitude, result sign and degenerate check
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_nxt[l] = numer_r[l][NUMER_W-1] ? MAG_W'(-numer_r[l]) : MAG_W'(numer_r[l]);
      neg_nxt[l] = numer_r[l][NUMER_W-1] ^ den_s_r[CROSS_W-1];
    end
    den_nxt   = den_s_r[CROSS_W-1] ? DEN_W'(-den_s_r) : DEN_W'(den_s_r);
    degen_nxt = (den_s_r == '0);
  end

  // --------------------------------------------------------------------------
  // stage 6: |n| * 2^16 + |d|/2 gives round-half-away after the floor divide
  // --------------------------------------------------------------------------
  always_comb begin
    s6_work_nxt       = '0;
    s6_work_nxt.den   = den_r;
    s6_work_nxt.degen = degen_r;
    s6_work_nxt.neg   = neg_r;
    for (int l = 0; l < LANES; l++) begin
      dividend[l] = {mag_r[l], FRAC_W'(0)} + DIVIDEND_W'(den_r >> 1);
      s6_work_nxt.rem[l] = DEN_W'(dividend[l][DIVIDEND_W-1 -: HEAD_W]);
      s6_work_nxt.sh[l]  = dividend[l][QUO_W-1:0];
    end
  end

  // front payload registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
    end
    if (adv2) begin
      prod_r <= prod_nxt;
    end
    if (adv3) begin
      u_r <= u_nxt;
    end
    if (adv4) begin
      numer_r <= numer_nxt;
      den_s_r <= u_r[2];
    end
    if (adv5) begin
      mag_r   <= mag_nxt;
      den_r   <= den_nxt;
      neg_r   <= neg_nxt;
      degen_r <= degen_nxt;
    end
    if (adv6) begin
      s6_work_r <= s6_work_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // quotient bits, one per stage
  // --------------------------------------------------------------------------
  tbw_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s6_vld_r),
    .in_ready  (div_in_ready),
    .in_work   (s6_work_r),
    .out_valid (div_out_valid),
    .out_ready (adv_out),
    .out_work  (div_out_work)
  );

  // --------------------------------------------------------------------------
  // output stage: sign, saturation and the degenerate constants
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      priority if (div_out_work.degen) begin
        weight_nxt[l] = (l == LANE_A) ? W_NEG_ONE : W_POS_ONE;
      end else if (!div_out_work.neg[l]) begin
        // positive: anything at or above 2^31 clamps
        weight_nxt[l] = (div_out_work.ovf[l] || div_out_work.sh[l][QUO_W-1] ||
                         div_out_work.sh[l][WEIGHT_W-1])
                        ? W_MAX : div_out_work.sh[l][WEIGHT_W-1:0];
      end else begin
        // negative: exactly 2^31 still fits
        weight_nxt[l] = (div_out_work.ovf[l] || (div_out_work.sh[l] > Q_NEG_LIM))
                        ? W_MIN : (~div_out_work.sh[l][WEIGHT_W-1:0] + WEIGHT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      weight_r    <= weight_nxt;
      out_degen_r <= div_out_work.degen;
    end
  end

  assign out_wgt.valid      = out_vld_r;
  assign out_wgt.weight_a   = weight_r[LANE_A];
  assign out_wgt.weight_b   = weight_r[LANE_B];
  assign out_wgt.weight_c   = weight_r[LANE_C];
  assign out_wgt.degenerate = out_degen_r;

`ifndef SYNTHESIS
  // an accepted pixel always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> s1_vld_r)
    else $error("accepted pixel lost at stage 1");

  // a full stage 6 blocked by the divider keeps its transaction
  a_s6_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s6_vld_r && !div_in_ready |=> s6_vld_r && $stable(s6_work_r))
    else $error("stage 6 transaction changed while stalled");

  // degenerate results carry -1, 1, 1
  a_degen_vals: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_degen_r
      |-> weight_r[LANE_A] == W_NEG_ONE && weight_r[LANE_B] == W_POS_ONE &&
          weight_r[LANE_C] == W_POS_ONE)
    else $error("degenerate result with wrong weights");
`endif

endmodule
